@@ design/csc_pkg.sv @@
package csc_pkg;

	// Widths and limits
	localparam int MAX_STEPS   = 32;
	localparam int ANGLE_WIDTH = 32;
	localparam int ITER_W      = 6;
	localparam int OUT_W       = 32;
	localparam int IDX_W       = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
	localparam int TW          = 62;            // range reduction word, Q.56
	localparam int ZW          = 59;            // residual angle in the cells, Q.56
	localparam int XYW         = 62;            // rotating vector, Q.60
	localparam int GAIN_W      = 32;            // gain, Q0.32
	localparam int MAG_W       = XYW + 1 - 30;  // scaled magnitude, Q.30
	localparam int AFRAC       = 56;
	localparam int GAIN_STEPS  = 31;
	localparam int Q56_ALIGN   = 61 - ANGLE_WIDTH;

	localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(20);

	// Angle constants, pi rounded to Q.56
	localparam logic [63:0] PI64 = 64'h03243F6A8885A309;
	localparam logic signed [TW-1:0] PI_T           = TW'(PI64);
	localparam logic signed [TW-1:0] TWO_PI_T       = TW'(PI64 << 1);
	localparam logic signed [TW-1:0] FOUR_PI_T      = TW'(PI64 << 2);
	localparam logic signed [TW-1:0] PI_LESS_HALF_T = TW'(PI64 - (PI64 >> 1));
	localparam logic signed [TW-1:0] PI_PLUS_HALF_T = TW'(PI64 + (PI64 >> 1));
	localparam logic signed [ZW-1:0] HALF_PI_Z      = ZW'(PI64 >> 1);
	localparam logic signed [ZW-1:0] NEG_HALF_PI_Z  = -HALF_PI_Z;

	// Vector and output constants
	localparam logic signed [XYW-1:0]   ONE_XY  = XYW'(64'h1000_0000_0000_0000);
	localparam logic [MAG_W-1:0]        ONE_Q30 = MAG_W'(64'h4000_0000);
	localparam logic signed [MAG_W:0]   SAT_HI  = (MAG_W+1)'(64'sd2147483647);
	localparam logic signed [MAG_W:0]   SAT_LO  = (MAG_W+1)'(-64'sd2147483648);
	localparam logic signed [OUT_W-1:0] Q30_POS = OUT_W'(64'sh4000_0000);
	localparam logic signed [OUT_W-1:0] Q30_NEG = OUT_W'(-64'sh4000_0000);

	// Control travelling alongside the data
	typedef struct packed {
		logic valid;
		logic neg;
	} csc_ctl_t;

	typedef struct packed {
		logic signed [XYW-1:0] x;
		logic signed [XYW-1:0] y;
		logic signed [ZW-1:0]  z;
	} csc_vec_t;

	typedef logic [MAX_STEPS-1:0][ZW-1:0]     csc_atan_tab_t;
	typedef logic [MAX_STEPS-1:0][GAIN_W-1:0] csc_gain_tab_t;

	// Arctangent of 2^-i in Q.56, truncated odd power series
	function automatic csc_atan_tab_t csc_build_atan();
		csc_atan_tab_t      tab;
		logic signed [63:0] sum;
		logic [63:0]        num;
		logic [63:0]        den;
		logic [63:0]        quo;
		logic [64:0]        rem;
		int                 i;
		int                 k;
		int                 e;
		int                 b;
		tab = '0;
		for (i = 0; i < MAX_STEPS; i++) begin
			if (i == 0) begin
				sum = $signed((PI64 + 64'd2) >> 2);
			end else begin
				sum = '0;
				for (k = 0; k < 32; k++) begin
					e = AFRAC - i * (2 * k + 1);
					if (e >= 0) begin
						num = 64'd1 << e;
						den = 64'(2 * k + 1);
						rem = '0;
						quo = '0;
						for (b = 63; b >= 0; b--) begin
							rem = {rem[63:0], num[b]};
							if (rem >= {1'b0, den}) begin
								rem    = rem - {1'b0, den};
								quo[b] = 1'b1;
							end
						end
						if (k[0]) begin
							sum = sum - $signed(quo);
						end else begin
							sum = sum + $signed(quo);
						end
					end
				end
			end
			tab[i] = ZW'(sum);
		end
		return tab;
	endfunction

	// Gain for each step count, floor(sqrt(P)) in Q0.32
	function automatic csc_gain_tab_t csc_build_gain();
		csc_gain_tab_t tab;
		logic [63:0]   p;
		logic [63:0]   den;
		logic [63:0]   quo;
		logic [64:0]   rem;
		logic [63:0]   v;
		logic [63:0]   res;
		logic [63:0]   bitv;
		int            i;
		int            b;
		int            s;
		tab = '0;
		p   = 64'h8000_0000_0000_0000;
		for (i = 0; i < MAX_STEPS; i++) begin
			if ((i >= 1) && (i <= GAIN_STEPS)) begin
				den = (64'd1 << (2 * i)) + 64'd1;
				rem = '0;
				quo = '0;
				for (b = 63; b >= 0; b--) begin
					rem = {rem[63:0], p[b]};
					if (rem >= {1'b0, den}) begin
						rem    = rem - {1'b0, den};
						quo[b] = 1'b1;
					end
				end
				p = p - quo;
			end
			v   = p;
			res = '0;
			for (s = 0; s < 32; s++) begin
				bitv = 64'd1 << (62 - 2 * s);
				if (v >= res + bitv) begin
					v   = v - (res + bitv);
					res = (res >> 1) + bitv;
				end else begin
					res = res >> 1;
				end
			end
			tab[i] = GAIN_W'(res);
		end
		return tab;
	endfunction

	localparam csc_atan_tab_t ATAN_TAB = csc_build_atan();
	localparam csc_gain_tab_t GAIN_TAB = csc_build_gain();

endpackage

@@ design/csc_reduce.sv @@
module csc_reduce (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     adv,
	input  logic                                     valid_in,
	input  logic signed [csc_pkg::ANGLE_WIDTH-1:0]   angle,
	output csc_pkg::csc_ctl_t                        ctl_out,
	output logic signed [csc_pkg::ZW-1:0]            theta_out
);
	import csc_pkg::*;

	logic                 valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic signed [TW-1:0] ext_a;
	logic signed [TW-1:0] t_d;
	logic signed [TW-1:0] t_s1, t_s2, t_s3, t_s4, t_s5;
	logic signed [TW-1:0] fold_d;
	logic                 neg_d;
	logic signed [ZW-1:0] theta_s6;
	logic                 neg_s6;

	// Angle into Q.56, offset by pi so the modulo lands in [0, 2pi)
	always_comb begin
		ext_a = {{(TW-ANGLE_WIDTH){angle[ANGLE_WIDTH-1]}}, angle};
		t_d   = (ext_a <<< Q56_ALIGN) + PI_T;
	end

	// Fold back into [-pi/2, pi/2]; either edge flips the sign of the result
	always_comb begin
		if (t_s5 < PI_LESS_HALF_T) begin
			fold_d = t_s5;
			neg_d  = 1'b1;
		end else if (t_s5 > PI_PLUS_HALF_T) begin
			fold_d = t_s5 - TWO_PI_T;
			neg_d  = 1'b1;
		end else begin
			fold_d = t_s5 - PI_T;
			neg_d  = 1'b0;
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// Modulo 2pi by conditional steps of 4pi and 2pi
	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1     <= t_d;
			t_s2     <= t_s1[TW-1] ? (t_s1 + FOUR_PI_T) : t_s1;
			t_s3     <= (t_s2 >= FOUR_PI_T) ? (t_s2 - FOUR_PI_T) : t_s2;
			t_s4     <= (t_s3 >= TWO_PI_T) ? (t_s3 - TWO_PI_T) : t_s3;
			t_s5     <= t_s4[TW-1] ? (t_s4 + TWO_PI_T) : t_s4;
			theta_s6 <= ZW'(fold_d);
			neg_s6   <= neg_d;
		end
	end

	always_comb begin
		ctl_out.valid = valid_s6;
		ctl_out.neg   = neg_s6;
		theta_out     = theta_s6;
	end

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_in |=> valid_s1)
		else $error("accepted angle did not enter the reduction pipe");

	a_modulo: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 |-> !t_s5[TW-1] && (t_s5 < TWO_PI_T))
		else $error("reduced angle outside [0, 2pi)");

	a_folded: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s6 |-> (theta_s6 >= NEG_HALF_PI_Z) && (theta_s6 <= HALF_PI_Z))
		else $error("folded angle outside [-pi/2, pi/2]");

endmodule

@@ design/csc_cell.sv @@
module csc_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  logic [csc_pkg::IDX_W-1:0]          step,
	input  logic signed [csc_pkg::ZW-1:0]      atan_c,
	input  logic [csc_pkg::ITER_W-1:0]         iterations,
	input  csc_pkg::csc_ctl_t                  ctl_in,
	input  csc_pkg::csc_vec_t                  vec_in,
	output csc_pkg::csc_ctl_t                  ctl_out,
	output csc_pkg::csc_vec_t                  vec_out
);
	import csc_pkg::*;

	logic signed [XYW-1:0] x, y, dx, dy;
	logic signed [ZW-1:0]  z;
	logic                  active;
	csc_vec_t              vec_d;
	csc_ctl_t              ctl_q;
	csc_vec_t              vec_q;

	// One micro-rotation; steps beyond the configured count pass the vector on
	always_comb begin
		x      = vec_in.x;
		y      = vec_in.y;
		z      = vec_in.z;
		dx     = y >>> step;
		dy     = x >>> step;
		active = iterations > ITER_W'(step);
		vec_d  = vec_in;
		if (active) begin
			if (!z[ZW-1]) begin
				vec_d.x = x - dx;
				vec_d.y = y + dy;
				vec_d.z = z - atan_c;
			end else begin
				vec_d.x = x + dx;
				vec_d.y = y - dy;
				vec_d.z = z + atan_c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (adv) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vec_q <= vec_d;
		end
	end

	assign ctl_out = ctl_q;
	assign vec_out = vec_q;

endmodule

@@ design/csc_scale.sv @@
module csc_scale (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  logic [csc_pkg::ITER_W-1:0]           iterations,
	input  csc_pkg::csc_ctl_t                    ctl_in,
	input  csc_pkg::csc_vec_t                    vec_in,
	output logic                                 out_valid,
	output logic signed [csc_pkg::OUT_W-1:0]     cosine,
	output logic signed [csc_pkg::OUT_W-1:0]     sine
);
	import csc_pkg::*;

	// Apply sign and clamp to the output range
	function automatic logic signed [OUT_W-1:0] csc_sat(input logic [MAG_W-1:0] mag,
			input logic neg);
		logic signed [MAG_W:0] v;
		v = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		if (v > SAT_HI) begin
			return OUT_W'(SAT_HI);
		end else if (v < SAT_LO) begin
			return OUT_W'(SAT_LO);
		end
		return OUT_W'(v);
	endfunction

	logic [IDX_W-1:0]        gsel;
	logic [XYW-1:0]          abs_x, abs_y;
	logic                    valid_s1, valid_s2, valid_s3;
	logic [XYW-1:0]          mag_x_s1, mag_y_s1;
	logic                    sgn_x_s1, sgn_y_s1, zero_s1;
	logic [GAIN_W-1:0]       gain_s1;
	logic [XYW-1:0]          hi_x_s2, hi_y_s2;
	logic [63:0]             lo_x_s2, lo_y_s2;
	logic                    sgn_x_s2, sgn_y_s2, zero_s2;
	logic [XYW:0]            sum_x, sum_y;
	logic [MAG_W-1:0]        r_x, r_y;
	logic signed [OUT_W-1:0] cos_s3, sin_s3;

	// Gain for the step count in use, magnitudes of the vector
	always_comb begin
		if (iterations >= ITER_W'(MAX_STEPS)) begin
			gsel = IDX_W'(MAX_STEPS - 1);
		end else begin
			gsel = IDX_W'(iterations - ITER_W'(1));
		end
		abs_x = vec_in.x[XYW-1] ? XYW'(-vec_in.x) : XYW'(vec_in.x);
		abs_y = vec_in.y[XYW-1] ? XYW'(-vec_in.y) : XYW'(vec_in.y);
	end

	// Product sums, truncated into Q.30
	always_comb begin
		sum_x = {1'b0, hi_x_s2} + (XYW+1)'(lo_x_s2 >> 32);
		sum_y = {1'b0, hi_y_s2} + (XYW+1)'(lo_y_s2 >> 32);
		r_x   = zero_s2 ? ONE_Q30 : sum_x[XYW:30];
		r_y   = zero_s2 ? '0 : sum_y[XYW:30];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= ctl_in.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Magnitude, gain select; split multiply; sign and saturate
	always_ff @(posedge clk) begin
		if (adv) begin
			mag_x_s1 <= abs_x;
			mag_y_s1 <= abs_y;
			sgn_x_s1 <= vec_in.x[XYW-1] ^ ctl_in.neg;
			sgn_y_s1 <= vec_in.y[XYW-1] ^ ctl_in.neg;
			zero_s1  <= (iterations == '0);
			gain_s1  <= GAIN_TAB[gsel];

			hi_x_s2  <= mag_x_s1[XYW-1:32] * gain_s1;
			lo_x_s2  <= mag_x_s1[31:0] * gain_s1;
			hi_y_s2  <= mag_y_s1[XYW-1:32] * gain_s1;
			lo_y_s2  <= mag_y_s1[31:0] * gain_s1;
			sgn_x_s2 <= sgn_x_s1;
			sgn_y_s2 <= sgn_y_s1;
			zero_s2  <= zero_s1;

			cos_s3   <= csc_sat(r_x, sgn_x_s2);
			sin_s3   <= csc_sat(r_y, sgn_y_s2);
		end
	end

	assign out_valid = valid_s3;
	assign cosine    = cos_s3;
	assign sine      = sin_s3;

	a_no_rotation: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && zero_s2 && adv |=> valid_s3 && (sin_s3 == '0)
			&& ((cos_s3 == Q30_POS) || (cos_s3 == Q30_NEG)))
		else $error("zero step count did not give the unit vector");

endmodule

@@ design/cordic_sine_cosine_top.sv @@
// Pipeline: 41 stages from an accepted angle to result_valid
// (6 reduction stages, one stage per CORDIC cell, 32 cells, 3 gain and saturation stages).
// Throughput: one angle per cycle; the whole pipe holds while a result is stalled.
// Reset (arst_n low, asynchronous): pipe emptied, iterations back to 20.
// Configuration transfers are always taken (cfg_ready high).
module cordic_sine_cosine_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  angle_valid,
	output logic                                  angle_stall,
	input  logic signed [csc_pkg::ANGLE_WIDTH-1:0] angle,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic signed [csc_pkg::OUT_W-1:0]      cosine,
	output logic signed [csc_pkg::OUT_W-1:0]      sine,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [csc_pkg::ITER_W-1:0]            iterations
);
	import csc_pkg::*;

	logic                 adv;
	logic [ITER_W-1:0]    iterations_q;
	csc_ctl_t             red_ctl;
	logic signed [ZW-1:0] red_theta;
	csc_ctl_t             ctl_c [MAX_STEPS+1];
	csc_vec_t             vec_c [MAX_STEPS+1];

	// Pipe moves unless a finished result is held back
	assign adv         = !(result_valid && result_stall);
	assign angle_stall = !adv;
	assign cfg_ready   = 1'b1;

	// Step count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iterations_q <= ITER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			iterations_q <= iterations;
		end
	end

	csc_reduce u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.valid_in  (angle_valid),
		.angle     (angle),
		.ctl_out   (red_ctl),
		.theta_out (red_theta)
	);

	// Rotation starts from (1, 0)
	always_comb begin
		ctl_c[0]   = red_ctl;
		vec_c[0].x = ONE_XY;
		vec_c[0].y = '0;
		vec_c[0].z = red_theta;
	end

	for (genvar i = 0; i < MAX_STEPS; i++) begin : g_cell
		csc_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.adv        (adv),
			.step       (IDX_W'(i)),
			.atan_c     (ATAN_TAB[i]),
			.iterations (iterations_q),
			.ctl_in     (ctl_c[i]),
			.vec_in     (vec_c[i]),
			.ctl_out    (ctl_c[i+1]),
			.vec_out    (vec_c[i+1])
		);
	end

	csc_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.iterations (iterations_q),
		.ctl_in     (ctl_c[MAX_STEPS]),
		.vec_in     (vec_c[MAX_STEPS]),
		.out_valid  (result_valid),
		.cosine     (cosine),
		.sine       (sine)
	);

endmodule
